FILE: design/fhp_pkg.sv
`default_nettype none
package fhp_pkg;

	typedef enum logic [1:0] {
		CMD_SEED    = 2'd0,
		CMD_PERTURB = 2'd1,
		CMD_PASS    = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	localparam logic [2:0] REG_MAX_HEAT   = 3'd0;
	localparam logic [2:0] REG_VERT       = 3'd1;
	localparam logic [2:0] REG_HORIZ      = 3'd2;
	localparam logic [2:0] REG_RESIDUAL   = 3'd3;
	localparam logic [2:0] REG_TREND      = 3'd4;
	localparam logic [2:0] REG_WIDTH      = 3'd5;
	localparam logic [2:0] REG_HEIGHT     = 3'd6;

	localparam logic [8:0] RST_MAX_HEAT   = 9'd300;
	localparam logic [7:0] RST_VERT       = 8'd78;
	localparam logic [7:0] RST_HORIZ      = 8'd26;
	localparam logic [7:0] RST_RESIDUAL   = 8'd68;
	localparam logic [3:0] RST_TREND      = 4'd2;
	localparam logic [7:0] RST_WIDTH      = 8'd128;
	localparam logic [7:0] RST_HEIGHT     = 8'd128;

	localparam logic [8:0]  GREEN_OFS     = 9'd80;
	localparam logic [8:0]  BLUE_OFS      = 9'd160;
	localparam logic [10:0] RAMP_MAX      = 11'd255;
	localparam logic [15:0] LIVE_MAX      = 16'hFFFF;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_PERT_RD,
		ST_PERT_WR,
		ST_READ_RD,
		ST_READ_WAIT,
		ST_DIV,
		ST_PASS_RD,
		ST_PASS_CLAMP,
		ST_PASS_MUL,
		ST_NB_RD,
		ST_NB_WR,
		ST_PASS_FIN,
		ST_DONE
	} state_t;

	function automatic logic [7:0] ramp3(input logic [8:0] p, input logic [8:0] ofs);
		logic [10:0] t;
		t = 11'd0;
		if (p >= ofs) begin
			t = 11'(p - ofs) * 11'd3;
		end
		ramp3 = (t > RAMP_MAX) ? 8'hFF : t[7:0];
	endfunction

endpackage
`default_nettype wire

FILE: design/fhp_grid_mem.sv
`default_nettype none
module fhp_grid_mem #(
	parameter int WIDTH = 16,
	parameter int AW    = 14,
	parameter int DEPTH = 16384
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

FILE: design/fhp_mod_unit.sv
`default_nettype none
module fhp_mod_unit import fhp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [8:0] dividend,
	input  wire logic [8:0] divisor,
	output logic            busy,
	output logic      [8:0] remainder
);

	logic [3:0] cnt_q;
	logic [9:0] rem_q;
	logic [8:0] dv_q;
	logic [8:0] dsr_q;
	logic [9:0] trial;

	assign trial = {rem_q[8:0], dv_q[8]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
		end else if (start) begin
			cnt_q <= 4'd9;
		end else if (cnt_q != 4'd0) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 10'd0;
			dv_q  <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != 4'd0) begin
			rem_q <= (trial >= {1'b0, dsr_q}) ? trial - {1'b0, dsr_q} : trial;
			dv_q  <= {dv_q[7:0], 1'b0};
		end
	end

	assign busy      = (cnt_q != 4'd0);
	assign remainder = (dsr_q == 9'd0) ? 9'd0 : rem_q[8:0];

endmodule
`default_nettype wire

FILE: design/fire_heat_propagation.sv
`default_nettype none
// Fire heat grid: a live heat grid and a shown copy, each in a one-port synchronous memory of
// MAX_ROWS x 2^COLS_LOG2 cells. After reset a clearing sweep zeroes both memories, one cell a
// cycle, during which no item is taken. Seed is one write, perturb a read, then a write, and
// read a memory read plus a remainder unit for the palette index. A pass is sequenced over
// the one live memory port: a cell that is not positive is read and clamped only, any other
// gets center read and clamp, multiply, six neighbor read-modify-writes and a final write.
// Every item gives one result; only a read carries nonzero fields.
module fire_heat_propagation import fhp_pkg::*; #(
	parameter int COLS_LOG2 = 7,
	parameter int MAX_ROWS  = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // column[6:0], row[13:7], amount[22:14], zero
	input  wire logic [1:0]  s_tuser,  // command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [55:0] m_tdata,  // shown_heat, live_heat, red, green, blue, zero
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [8:0]  cfg_data
);

	localparam int CL    = COLS_LOG2;
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int AW    = RW + CL;
	localparam int DEPTH = MAX_ROWS << CL;
	localparam int EW    = (CL + 1 > 8) ? CL + 1 : 8;
	localparam int HW    = ($clog2(MAX_ROWS + 1) > 8) ? $clog2(MAX_ROWS + 1) : 8;

	state_t state_q, state_d;

	logic [8:0] max_heat_q;
	logic [7:0] vert_q, horiz_q, resid_q, width_q, height_q;
	logic [3:0] trend_q;

	logic [EW-1:0] eff_w;
	logic [HW-1:0] eff_h;

	cmd_t       in_cmd;
	logic [6:0] in_col, in_row;
	logic [8:0] in_amt;

	logic [6:0]    col_q, row_q;
	logic [8:0]    amt_q;
	logic          rd_ok_q;
	logic [CL-1:0] x_q;
	logic [RW-1:0] y_q;
	logic [2:0]    nb_q;
	logic [8:0]    v_q;
	logic [8:0]    vt_q, ht_q, dec_q;
	logic [8:0]    shown_q;
	logic [15:0]   live_q;
	logic [AW-1:0] clr_q;
	logic [55:0]   m_tdata_q;
	logic          m_tvalid_q;

	logic          live_we, shown_we;
	logic [AW-1:0] live_addr, shown_addr;
	logic [15:0]   live_wdata, live_rdata;
	logic [8:0]    shown_wdata, shown_rdata;

	logic          mod_start, mod_busy;
	logic [8:0]    mod_rem;

	logic          seed_ok, read_ok, pass_small;
	logic          col_more, row_more, pass_last;
	logic [8:0]    clamp_v;
	logic          over_max;
	logic [16:0]   pert_sum;
	logic [16:0]   pert_diff;
	logic [15:0]   pert_val;
	logic [RW-1:0] nb_y;
	logic [CL-1:0] nb_x;
	logic [8:0]    nb_add;
	logic [16:0]   nb_sum;
	logic [RW-1:0] bot_row;
	logic          m_load;
	logic [7:0]    red, green, blue;

	assign in_cmd = cmd_t'(s_tuser);
	assign in_col = s_tdata[6:0];
	assign in_row = s_tdata[13:7];
	assign in_amt = s_tdata[22:14];

	assign eff_w = (EW'(width_q) < EW'(1 << CL)) ? EW'(width_q) : EW'(1 << CL);
	assign eff_h = (HW'(height_q) < HW'(MAX_ROWS)) ? HW'(height_q) : HW'(MAX_ROWS);
	assign bot_row = RW'(eff_h - HW'(1));

	assign seed_ok    = (eff_h != HW'(0)) && (EW'(in_col) < eff_w);
	assign read_ok    = (HW'(in_row) < eff_h) && (EW'(in_col) < eff_w);
	assign pass_small = (eff_h < HW'(3)) || (eff_w < EW'(3));
	assign col_more   = (EW'(x_q) + EW'(2)) < eff_w;
	assign row_more   = y_q > RW'(2);
	assign pass_last  = !col_more && !row_more;

	assign over_max = live_rdata > 16'(max_heat_q);
	assign clamp_v  = over_max ? max_heat_q : live_rdata[8:0];

	assign pert_sum  = 17'(live_rdata) + 17'(amt_q);
	assign pert_diff = pert_sum - 17'(trend_q);
	assign pert_val  = ((pert_sum < 17'(trend_q)) || (pert_diff > 17'(max_heat_q))) ?
		16'd0 : pert_diff[15:0];

	always_comb begin
		nb_y   = y_q;
		nb_x   = x_q;
		nb_add = 9'd0;
		case (nb_q)
			3'd0: begin
				nb_y   = y_q - RW'(2);
				nb_add = {1'b0, vt_q[8:1]};
			end
			3'd1: begin
				nb_y   = y_q - RW'(1);
				nb_add = vt_q;
			end
			3'd2: begin
				nb_y   = y_q - RW'(1);
				nb_x   = x_q - CL'(1);
				nb_add = ht_q;
			end
			3'd3: begin
				nb_y   = y_q - RW'(1);
				nb_x   = x_q + CL'(1);
				nb_add = ht_q;
			end
			3'd4: begin
				nb_x   = x_q - CL'(1);
				nb_add = {1'b0, ht_q[8:1]};
			end
			3'd5: begin
				nb_x   = x_q + CL'(1);
				nb_add = {1'b0, ht_q[8:1]};
			end
			default: begin
				nb_add = 9'd0;
			end
		endcase
	end

	assign nb_sum = 17'(live_rdata) + 17'(nb_add);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR: begin
				if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					case (in_cmd)
						CMD_PERTURB: state_d = seed_ok ? ST_PERT_RD : ST_DONE;
						CMD_PASS:    state_d = pass_small ? ST_DONE : ST_PASS_RD;
						CMD_READ:    state_d = read_ok ? ST_READ_RD : ST_DONE;
						default:     state_d = ST_DONE;
					endcase
				end
			end
			ST_PERT_RD:   state_d = ST_PERT_WR;
			ST_PERT_WR:   state_d = ST_DONE;
			ST_READ_RD:   state_d = ST_READ_WAIT;
			ST_READ_WAIT: state_d = ST_DIV;
			ST_DIV: begin
				if (!mod_busy) state_d = ST_DONE;
			end
			ST_PASS_RD:   state_d = ST_PASS_CLAMP;
			ST_PASS_CLAMP: begin
				if (clamp_v != 9'd0) state_d = ST_PASS_MUL;
				else if (pass_last) state_d = ST_DONE;
				else state_d = ST_PASS_RD;
			end
			ST_PASS_MUL:  state_d = ST_NB_RD;
			ST_NB_RD:     state_d = ST_NB_WR;
			ST_NB_WR:     state_d = (nb_q == 3'd5) ? ST_PASS_FIN : ST_NB_RD;
			ST_PASS_FIN:  state_d = pass_last ? ST_DONE : ST_PASS_RD;
			ST_DONE: begin
				if (m_load) state_d = ST_IDLE;
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		live_we     = 1'b0;
		shown_we    = 1'b0;
		live_addr   = {y_q, x_q};
		shown_addr  = {y_q, x_q};
		live_wdata  = 16'd0;
		shown_wdata = v_q;
		mod_start   = 1'b0;
		case (state_q)
			ST_CLR: begin
				live_we     = 1'b1;
				shown_we    = 1'b1;
				live_addr   = clr_q;
				shown_addr  = clr_q;
				shown_wdata = 9'd0;
			end
			ST_IDLE: begin
				live_addr  = {bot_row, CL'(in_col)};
				live_wdata = 16'(in_amt);
				live_we    = s_tvalid && (in_cmd == CMD_SEED) && seed_ok;
			end
			ST_PERT_RD, ST_PERT_WR: begin
				live_addr  = {bot_row, CL'(col_q)};
				live_wdata = pert_val;
				live_we    = (state_q == ST_PERT_WR);
			end
			ST_READ_RD: begin
				live_addr  = {RW'(row_q), CL'(col_q)};
				shown_addr = {RW'(row_q), CL'(col_q)};
			end
			ST_READ_WAIT: begin
				mod_start = 1'b1;
			end
			ST_PASS_CLAMP: begin
				live_wdata = 16'(max_heat_q);
				live_we    = over_max;
			end
			ST_NB_RD, ST_NB_WR: begin
				live_addr  = {nb_y, nb_x};
				live_wdata = nb_sum[16] ? LIVE_MAX : nb_sum[15:0];
				live_we    = (state_q == ST_NB_WR);
			end
			ST_PASS_FIN: begin
				shown_we   = 1'b1;
				live_wdata = 16'(dec_q);
				live_we    = y_q != bot_row;
			end
			default: begin
				live_we = 1'b0;
			end
		endcase
	end

	assign m_load = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
			x_q        <= '0;
			y_q        <= '0;
			nb_q       <= 3'd0;
			max_heat_q <= RST_MAX_HEAT;
			vert_q     <= RST_VERT;
			horiz_q    <= RST_HORIZ;
			resid_q    <= RST_RESIDUAL;
			trend_q    <= RST_TREND;
			width_q    <= RST_WIDTH;
			height_q   <= RST_HEIGHT;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) clr_q <= clr_q + AW'(1);
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_HEAT: max_heat_q <= cfg_data;
					REG_VERT:     vert_q     <= cfg_data[7:0];
					REG_HORIZ:    horiz_q    <= cfg_data[7:0];
					REG_RESIDUAL: resid_q    <= cfg_data[7:0];
					REG_TREND:    trend_q    <= cfg_data[3:0];
					REG_WIDTH:    width_q    <= cfg_data[7:0];
					REG_HEIGHT:   height_q   <= cfg_data[7:0];
					default:      ;
				endcase
			end
			if (state_q == ST_DONE && m_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			if (state_q == ST_IDLE && s_tvalid) begin
				y_q  <= bot_row;
				x_q  <= CL'(1);
			end
			if (state_q == ST_PASS_MUL) nb_q <= 3'd0;
			if (state_q == ST_NB_WR) nb_q <= nb_q + 3'd1;
			if ((state_q == ST_PASS_FIN) ||
			    (state_q == ST_PASS_CLAMP && clamp_v == 9'd0)) begin
				if (col_more) begin
					x_q <= x_q + CL'(1);
				end else begin
					x_q <= CL'(1);
					y_q <= y_q - RW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			col_q   <= in_col;
			row_q   <= in_row;
			amt_q   <= in_amt;
			rd_ok_q <= (in_cmd == CMD_READ) && read_ok;
		end
		if (state_q == ST_PASS_CLAMP) v_q <= clamp_v;
		if (state_q == ST_PASS_MUL) begin
			vt_q  <= 9'((17'(v_q) * 17'(vert_q)) >> 8);
			ht_q  <= 9'((17'(v_q) * 17'(horiz_q)) >> 8);
			dec_q <= 9'((17'(v_q) * 17'(resid_q)) >> 8);
		end
		if (state_q == ST_READ_WAIT) begin
			shown_q <= shown_rdata;
			live_q  <= live_rdata;
		end
		if (state_q == ST_DONE && m_load) begin
			m_tdata_q <= rd_ok_q ? {7'd0, blue, green, red, live_q, shown_q} : 56'd0;
		end
	end

	assign red   = ramp3(mod_rem, 9'd0);
	assign green = ramp3(mod_rem, GREEN_OFS);
	assign blue  = ramp3(mod_rem, BLUE_OFS);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	fhp_grid_mem #(.WIDTH(16), .AW(AW), .DEPTH(DEPTH)) u_live (
		.clk   (clk),
		.we    (live_we),
		.addr  (live_addr),
		.wdata (live_wdata),
		.rdata (live_rdata)
	);

	fhp_grid_mem #(.WIDTH(9), .AW(AW), .DEPTH(DEPTH)) u_shown (
		.clk   (clk),
		.we    (shown_we),
		.addr  (shown_addr),
		.wdata (shown_wdata),
		.rdata (shown_rdata)
	);

	fhp_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (shown_rdata),
		.divisor   (max_heat_q),
		.busy      (mod_busy),
		.remainder (mod_rem)
	);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item taken while another is in flight");

	a_pass_col: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PASS_RD |-> (x_q != '0) && ((EW'(x_q) + EW'(1)) < eff_w))
		else $error("pass column outside the interior");

	a_pass_row: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PASS_RD |-> (y_q >= RW'(2)) && (HW'(y_q) < eff_h))
		else $error("pass row outside the active rows");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ_WAIT |=> mod_busy)
		else $error("remainder unit did not start");

endmodule
`default_nettype wire
